>>> rtl/nq_pkg.sv
// Shared constants and controller/datapath interface types for the N-queens enumerator.
// No dependencies.
package nq_pkg;

  localparam int MAX_N   = 16;
  localparam int ROW_W   = $clog2(MAX_N);
  localparam int CNT_W   = $clog2(MAX_N + 1);
  localparam int DIAG_N  = 2 * MAX_N - 1;
  localparam int DIAG_IW = $clog2(DIAG_N);
  localparam int CFG_W   = 5;
  localparam int ROWO_W  = 5;
  localparam int OUT_DW  = ((ROW_W + ROWO_W + 7) / 8) * 8;
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

  typedef struct packed {
    logic clear;
    logic cfg_wr;
    logic prep;
    logic step;
    logic emit;
    logic exh;
  } nq_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    logic first_col;
    logic last_col;
    logic emit_last;
    logic out_free;
  } nq_sts_t;

endpackage

>>> rtl/nq_ctrl.sv
// Sequencing state machine: configuration and request intake, search stepping, result emission.
// Depends on nq_pkg.
module nq_ctrl import nq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    restart,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  nq_sts_t sts,
  output nq_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_EXH    = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.clear  = 1'b1;
          cmd.cfg_wr = 1'b1;
        end
        if (in_tvalid) begin
          if (restart) cmd.clear = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.done) begin
          state_nxt = ST_EXH;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.found && sts.last_col) state_nxt = ST_EMIT;
        else if (!sts.found && sts.first_col) state_nxt = ST_EXH;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = ST_IDLE;
        end
      end
      ST_EXH: begin
        if (sts.out_free) begin
          cmd.exh   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !sts.done) else $error("emitting after exhaustion");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.prep, cmd.step, cmd.emit, cmd.exh})) else $error("conflicting commands");

endmodule

>>> rtl/nq_dp.sv
// Search datapath: occupancy marks, placed rows, column counter, free-row finder,
// and the output register. Depends on nq_pkg.
module nq_dp import nq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  nq_cmd_t             cmd,
  input  logic [CFG_W-1:0]    cfg_data,
  output nq_sts_t             sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_DW-1:0]   out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  logic [CFG_W-1:0]  size_r;
  logic [MAX_N-1:0]  row_taken_r, row_taken_nxt;
  logic [DIAG_N-1:0] sum_taken_r, sum_taken_nxt;
  logic [DIAG_N-1:0] diff_taken_r, diff_taken_nxt;
  logic [ROW_W-1:0]  placed_r [MAX_N];
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic              done_r;
  logic [ROW_W-1:0]  emit_k_r;
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_col_r;
  logic [ROWO_W-1:0] out_row_r;
  logic              out_last_r;
  logic              out_exh_r;

  logic [CNT_W-1:0]  n_eff;
  logic [ROW_W-1:0]  rd_addr;
  logic [ROW_W-1:0]  rd_row;
  logic [MAX_N-1:0]  sum_win, diff_win, range_m, free_m, low_m;
  logic [ROW_W-1:0]  r_sel;
  logic              found;
  logic              mark_en, mark_set;
  logic [ROW_W-1:0]  mark_r;
  logic [CNT_W-1:0]  mark_c;
  logic [DIAG_IW-1:0] sum_idx, diff_idx;
  logic [DIAG_N-1:0] sum_oh, diff_oh;
  logic [MAX_N-1:0]  row_oh;
  logic [CNT_W-1:0]  col_m1;
  logic              out_free;

  always_comb begin
    if (size_r == '0) n_eff = CNT_W'(1);
    else if (CNT_W'(size_r) > CNT_W'(MAX_N)) n_eff = CNT_W'(MAX_N);
    else n_eff = CNT_W'(size_r);
  end

  assign col_m1 = col_r - CNT_W'(1);

  always_comb begin
    priority if (cmd.prep) rd_addr = ROW_W'(n_eff - CNT_W'(1));
    else if (cmd.step) rd_addr = col_m1[ROW_W-1:0];
    else rd_addr = emit_k_r;
  end
  assign rd_row = placed_r[rd_addr];

  assign sum_win  = MAX_N'(sum_taken_r >> col_r);
  assign diff_win = MAX_N'(diff_taken_r >> (CNT_W'(MAX_N - 1) - col_r));

  always_comb begin
    for (int i = 0; i < MAX_N; i++) begin
      range_m[i] = (CNT_W'(i) >= start_r) && (CNT_W'(i) < n_eff);
    end
  end

  assign free_m = ~(row_taken_r | sum_win | diff_win) & range_m;
  assign low_m  = free_m & (~free_m + MAX_N'(1));
  assign found  = |free_m;

  always_comb begin
    r_sel = '0;
    for (int i = 0; i < MAX_N; i++) begin
      if (low_m[i]) r_sel = r_sel | ROW_W'(i);
    end
  end

  always_comb begin
    mark_en  = 1'b0;
    mark_set = 1'b0;
    mark_r   = rd_row;
    mark_c   = col_m1;
    start_nxt = start_r;
    col_nxt   = col_r;
    if (cmd.prep) begin
      if (col_r >= n_eff) begin
        mark_en   = 1'b1;
        mark_c    = n_eff - CNT_W'(1);
        col_nxt   = n_eff - CNT_W'(1);
        start_nxt = CNT_W'(rd_row) + CNT_W'(1);
      end else begin
        start_nxt = '0;
      end
    end else if (cmd.step) begin
      if (found) begin
        mark_en   = 1'b1;
        mark_set  = 1'b1;
        mark_r    = r_sel;
        mark_c    = col_r;
        col_nxt   = col_r + CNT_W'(1);
        start_nxt = '0;
      end else if (col_r != '0) begin
        mark_en   = 1'b1;
        col_nxt   = col_m1;
        start_nxt = CNT_W'(rd_row) + CNT_W'(1);
      end
    end
  end

  assign sum_idx  = DIAG_IW'(mark_r) + DIAG_IW'(mark_c);
  assign diff_idx = DIAG_IW'(mark_r) + DIAG_IW'(MAX_N - 1) - DIAG_IW'(mark_c);
  assign row_oh   = MAX_N'(1) << mark_r;
  assign sum_oh   = DIAG_N'(1) << sum_idx;
  assign diff_oh  = DIAG_N'(1) << diff_idx;

  always_comb begin
    row_taken_nxt  = row_taken_r;
    sum_taken_nxt  = sum_taken_r;
    diff_taken_nxt = diff_taken_r;
    if (mark_en) begin
      if (mark_set) begin
        row_taken_nxt  = row_taken_r | row_oh;
        sum_taken_nxt  = sum_taken_r | sum_oh;
        diff_taken_nxt = diff_taken_r | diff_oh;
      end else begin
        row_taken_nxt  = row_taken_r & ~row_oh;
        sum_taken_nxt  = sum_taken_r & ~sum_oh;
        diff_taken_nxt = diff_taken_r & ~diff_oh;
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= SIZE_RESET;
      row_taken_r  <= '0;
      sum_taken_r  <= '0;
      diff_taken_r <= '0;
      col_r        <= '0;
      start_r      <= '0;
      done_r       <= 1'b0;
      emit_k_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.cfg_wr) size_r <= cfg_data;
      if (cmd.clear) begin
        row_taken_r  <= '0;
        sum_taken_r  <= '0;
        diff_taken_r <= '0;
        col_r        <= '0;
        done_r       <= 1'b0;
      end else begin
        row_taken_r  <= row_taken_nxt;
        sum_taken_r  <= sum_taken_nxt;
        diff_taken_r <= diff_taken_nxt;
        col_r        <= col_nxt;
        if (cmd.step && !found && col_r == '0) done_r <= 1'b1;
      end
      start_r <= start_nxt;
      if (cmd.prep) emit_k_r <= '0;
      else if (cmd.emit) emit_k_r <= emit_k_r + ROW_W'(1);
      if (cmd.emit || cmd.exh) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && found) placed_r[col_r[ROW_W-1:0]] <= r_sel;
    if (cmd.emit) begin
      out_col_r  <= emit_k_r;
      out_row_r  <= ROWO_W'(rd_row) + ROWO_W'(1);
      out_last_r <= (CNT_W'(emit_k_r) == n_eff - CNT_W'(1));
      out_exh_r  <= 1'b0;
    end else if (cmd.exh) begin
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_last_r <= 1'b1;
      out_exh_r  <= 1'b1;
    end
  end

  assign sts.done      = done_r;
  assign sts.found     = found;
  assign sts.first_col = (col_r == '0);
  assign sts.last_col  = (col_r + CNT_W'(1) == n_eff);
  assign sts.emit_last = (CNT_W'(emit_k_r) == n_eff - CNT_W'(1));
  assign sts.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_row_r, out_col_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_exh_r;

  a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(row_taken_r) == 32'(col_r)) else $error("row marks out of step with column");
  a_sum_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(sum_taken_r) == 32'(col_r)) else $error("sum diagonal marks out of step");
  a_diff_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(diff_taken_r) == 32'(col_r)) else $error("diff diagonal marks out of step");
  a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast) else $error("exhausted result not marked last");

endmodule

>>> rtl/n_queens_solution_enumerator.sv
// Top level of the N-queens enumerator: joins controller and datapath.
// Depends on nq_pkg, nq_ctrl, nq_dp.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_tvalid/in_tready   | in_tdata[0] restart
//  out     | out | out_tvalid/out_tready | out_tdata column[3:0] queen_row[8:4]; tlast; tuser exhausted
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_data board_size
//
// Setup runs through the PREP state; the search then takes one step per cycle (each step places a
// queen in one column or backs up one column); results leave one per cycle while out_tready is high.
// The number of search steps depends on board size and solution position.
// Reset (rst_n low, synchronous) restores board size 8 and an empty board.
// Output stalls hold emission; a new request is taken while the last result still waits.
module n_queens_solution_enumerator import nq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [0] restart
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_DW-1:0]   out_tdata,  // [3:0] column, [8:4] queen_row
  output logic                out_tlast,  // last
  output logic                out_tuser,  // [0] exhausted
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  nq_cmd_t cmd;
  nq_sts_t sts;

  nq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .restart   (in_tdata[0]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_data   (cfg_data),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> tb/n_queens_solution_enumerator_tb.sv
// Self-checking testbench for n_queens_solution_enumerator: directed and random requests,
// with an internal backtracking predictor checking every result transaction.
// Depends on nq_pkg and the n_queens_solution_enumerator RTL.
module n_queens_solution_enumerator_tb import nq_pkg::*; ();

  localparam int STUCK_LIMIT = 200000;

  typedef struct packed {
    logic [3:0] column;
    logic [4:0] queen_row;
    logic       last;
    logic       exhausted;
  } queen_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;

  n_queens_solution_enumerator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [CFG_W-1:0] size_setting;
  logic [3:0]       queen_at  [MAX_N];
  bit               row_busy  [MAX_N];
  bit               anti_busy [DIAG_N];
  bit               diag_busy [DIAG_N];
  int               depth;
  bit               finished;

  queen_result_t solution_q[$];
  int            fail_count;
  int            sink_hold;
  bit            burst_mode;
  int            stuck_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int board_edge();
    if (size_setting == 0) return 1;
    if (size_setting > MAX_N) return MAX_N;
    return int'(size_setting);
  endfunction

  function automatic void wipe_board();
    foreach (queen_at[i]) queen_at[i] = '0;
    foreach (row_busy[i]) row_busy[i] = 1'b0;
    foreach (anti_busy[i]) anti_busy[i] = 1'b0;
    foreach (diag_busy[i]) diag_busy[i] = 1'b0;
    depth    = 0;
    finished = 1'b0;
  endfunction

  function automatic void mark(input int r, input int c, input bit v);
    row_busy[r]               = v;
    anti_busy[r + c]          = v;
    diag_busy[r + MAX_N-1 - c] = v;
  endfunction

  function automatic bit square_open(input int r, input int c);
    return !row_busy[r] && !anti_busy[r + c] && !diag_busy[r + MAX_N-1 - c];
  endfunction

  // advance the search by one request and queue the results it yields
  function automatic void predict_request(input bit restart_bit);
    int            n;
    int            c;
    int            r;
    int            first;
    bit            found;
    queen_result_t res;
    n     = board_edge();
    found = 1'b0;
    if (restart_bit) wipe_board();
    if (!finished) begin
      c     = (depth > n) ? n : depth;
      first = 0;
      if (c == n) begin
        c     = n - 1;
        r     = queen_at[c];
        mark(r, c, 1'b0);
        first = r + 1;
      end
      forever begin
        r = first;
        while (r < n && !square_open(r, c)) r++;
        if (r < n) begin
          mark(r, c, 1'b1);
          queen_at[c] = 4'(r);
          c++;
          if (c == n) begin
            depth = n;
            found = 1'b1;
            break;
          end
          first = 0;
        end else if (c == 0) begin
          finished = 1'b1;
          depth    = 0;
          break;
        end else begin
          c--;
          r = queen_at[c];
          mark(r, c, 1'b0);
          first = r + 1;
        end
      end
    end
    if (found) begin
      for (int k = 0; k < n; k++) begin
        res.column    = 4'(k);
        res.queen_row = 5'(queen_at[k]) + 5'd1;
        res.last      = (k == n - 1);
        res.exhausted = 1'b0;
        solution_q.push_back(res);
      end
    end else begin
      res = '{column: 4'd0, queen_row: 5'd0, last: 1'b1, exhausted: 1'b1};
      solution_q.push_back(res);
    end
  endfunction

  // returns at the accepting edge; the caller's next step must send again or drain
  task automatic send_request(input bit restart_bit);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart_bit};
    do @(posedge clk); while (!in_tready);
    predict_request(restart_bit);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (solution_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_board_size(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    size_setting = value;
    wipe_board();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random pauses per transaction, none in burst mode, or a long hold when asked
  initial begin : result_sink
    int unsigned pause;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        pause     = sink_hold;
        sink_hold = 0;
      end else if (burst_mode) begin
        pause = 0;
      end else begin
        pause = $urandom_range(0, 8);
      end
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid || !rst_n);
    end
  end

  always @(posedge clk) begin : result_check
    queen_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (solution_q.size() == 0) begin
        $error("unexpected result: column %0d queen_row %0d last %0b exhausted %0b",
               out_tdata[3:0], out_tdata[8:4], out_tlast, out_tuser);
        fail_count++;
      end else begin
        want = solution_q.pop_front();
        if (out_tdata[3:0] !== want.column) begin
          $error("column: expected %0d, actual %0d", want.column, out_tdata[3:0]);
          fail_count++;
        end
        if (out_tdata[8:4] !== want.queen_row) begin
          $error("queen_row: expected %0d, actual %0d", want.queen_row, out_tdata[8:4]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          fail_count++;
        end
        if (out_tuser !== want.exhausted) begin
          $error("exhausted: expected %0b, actual %0b", want.exhausted, out_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("n_queens_solution_enumerator_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic test_default_board();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // single solution, no solution, out-of-range zero, repeated exhaustion
  task automatic test_tiny_boards();
    write_board_size(5'd1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    write_board_size(5'd0);
    send_request(1'b0);
    send_request(1'b0);
    write_board_size(5'd2);
    send_request(1'b0);
    send_request(1'b1);
    write_board_size(5'd3);
    send_request(1'b0);
    write_board_size(5'd4);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // above-range size acts as the largest board
  task automatic test_largest_board();
    write_board_size(5'd16);
    send_request(1'b0);
    write_board_size(5'd31);
    send_request(1'b1);
  endtask

  task automatic test_size_write_restarts();
    write_board_size(5'd6);
    send_request(1'b0);
    send_request(1'b0);
    write_board_size(5'd6);
    send_request(1'b0);
  endtask

  task automatic test_output_backpressure();
    write_board_size(5'd5);
    sink_hold = 400;
    for (int i = 0; i < 6; i++) send_request(1'b0);
  endtask

  task automatic test_random_walk();
    int unsigned      sent;
    int unsigned      run_len;
    logic [CFG_W-1:0] size_pick;
    sent = 0;
    while (sent < 80) begin
      case ($urandom_range(0, 15))
        0:       size_pick = 5'd0;
        1:       size_pick = 5'd1;
        2:       size_pick = 5'd2;
        3:       size_pick = 5'd3;
        default: size_pick = 5'($urandom_range(4, 8));
      endcase
      write_board_size(size_pick);
      burst_mode = ($urandom_range(0, 3) == 0);
      run_len    = $urandom_range(4, 20);
      for (int k = 0; k < run_len; k++) send_request($urandom_range(0, 9) == 0);
      sent += run_len;
      wait_for_results();
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    fail_count   = 0;
    sink_hold    = 0;
    burst_mode   = 1'b0;
    stuck_cycles = 0;
    size_setting = SIZE_RESET;
    wipe_board();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_default_board();
    test_tiny_boards();
    test_largest_board();
    test_size_write_restarts();
    test_output_backpressure();
    test_random_walk();
    wait_for_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("n_queens_solution_enumerator_tb passed");
    end else begin
      $display("n_queens_solution_enumerator_tb failed");
    end
    $finish;
  end

endmodule
